// ===== src/gbte_pkg.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text engine package
// Shared command kinds, status codes, register indexes and the command record.
// ----------------------------------------------------------------------------
`default_nettype none

package gbte_pkg;

  localparam int CAPACITY = 4096;

  localparam int OPCODE_W = 3;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 14;
  localparam int POS_W    = 13;
  localparam int SIZE_W   = 13;
  localparam int WARN_W   = 7;
  localparam int PROD_W   = SIZE_W + WARN_W;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_MOVE   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_JUMP   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_LINE   = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_WARN = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  localparam logic CFG_BUFFER_SIZE  = 1'b0;
  localparam logic CFG_WARN_PERCENT = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_VT = 8'd11;
  localparam logic [CHAR_W-1:0] CHAR_FF = 8'd12;

  localparam logic [WARN_W-1:0] WARN_MAX = 7'd100;

  // Floor of a product divided by 100, exact for products below 2^20.
  localparam logic [PROD_W-1:0] RECIP_100 = 20'd671089;
  localparam int                RECIP_SHIFT = 26;

  typedef enum logic [2:0] {
    K_INSERT, K_DELETE, K_MOVE, K_JUMP, K_READ, K_CLEAR, K_LINE, K_BAD
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [CHAR_W-1:0]          ch;
    logic signed [COUNT_W-1:0]  cnt;
    logic [COUNT_W-1:0]         mag;
    logic                       neg;
    logic                       zero;
    logic                       clamp;
  } cmd_t;

  function automatic logic is_term(input logic [CHAR_W-1:0] c);
    return (c == CHAR_LF) || (c == CHAR_VT) || (c == CHAR_FF);
  endfunction

endpackage

`default_nettype wire

// ===== src/gbte_front.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text engine front end
// Accepts command beats, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gbte_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [23:0]                     s_tdata,
  input  wire logic [gbte_pkg::OPCODE_W-1:0]   s_tuser,
  output logic                                 cmd_valid,
  output gbte_pkg::cmd_t                       cmd,
  input  wire logic                            cmd_pop
);
  import gbte_pkg::*;

  cmd_t        q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  cmd_t        dec;
  logic        push;

  always_comb begin
    dec.ch    = s_tdata[7:0];
    dec.cnt   = $signed(s_tdata[21:8]);
    dec.clamp = s_tdata[22];
    dec.neg   = s_tdata[21];
    dec.zero  = (s_tdata[21:8] == '0);
    dec.mag   = s_tdata[21] ? (~s_tdata[21:8] + 14'd1) : s_tdata[21:8];
    case (s_tuser)
      OP_INSERT: dec.kind = K_INSERT;
      OP_DELETE: dec.kind = K_DELETE;
      OP_MOVE:   dec.kind = K_MOVE;
      OP_JUMP:   dec.kind = K_JUMP;
      OP_READ:   dec.kind = K_READ;
      OP_CLEAR:  dec.kind = K_CLEAR;
      OP_LINE:   dec.kind = K_LINE;
      default:   dec.kind = K_BAD;
    endcase
  end

  assign s_tready  = (fill != 2'd2);
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

`default_nettype wire

// ===== src/gbte_back.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text engine back end
// Executes commands against the text store and registers each result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gbte_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [gbte_pkg::SIZE_W-1:0]   buffer_size,
  input  wire logic [gbte_pkg::WARN_W-1:0]   warn_percent,
  input  wire logic                          cmd_valid,
  input  wire gbte_pkg::cmd_t                cmd_in,
  output logic                               cmd_pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [47:0]                        m_tdata,
  output logic [2:0]                         m_tuser
);
  import gbte_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MUL1, S_MUL2, S_GAP_RD, S_GAP_WR, S_INS, S_DEL,
    S_RD_ISSUE, S_RD_TAKE, S_SCAN_RD, S_SCAN_CHK, S_DONE
  } state_t;

  logic [CHAR_W-1:0] mem [CAPACITY];
  logic [CHAR_W-1:0] rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CHAR_W-1:0] wr_data;

  state_t             state;
  cmd_t               cmd;
  logic [CW-1:0]      below;
  logic [CW-1:0]      after;
  logic [CW-1:0]      cursor;
  logic [CW-1:0]      scan_p;
  logic [COUNT_W-1:0] found;
  logic [PROD_W-1:0]  prod;
  logic [SIZE_W-1:0]  low;
  logic               gap_back;
  logic               post_ins;
  logic [1:0]         res_status;
  logic [CHAR_W-1:0]  res_char;
  logic               res_cvalid;
  logic [COUNT_W-1:0] res_dist;

  logic [CW-1:0]      len;
  logic [SIZE_W-1:0]  size_u;
  logic [WARN_W-1:0]  warn_u;
  logic [WW-1:0]      gap_w;
  logic [2*PROD_W-1:0] low_full;
  logic [WW:0]        p_s;
  logic               p_ok;
  logic [WW-1:0]      d_len;
  logic [WW-1:0]      d_p;
  logic [WW-1:0]      d_p1;
  logic [WW-1:0]      d_zero;
  logic [CW-1:0]      scan_q;
  logic [CW+POS_W-1:0] cur_ext;
  logic [CW+POS_W-1:0] len_ext;

  function automatic logic [AW-1:0] phys(input logic [CW-1:0] p, input logic [CW-1:0] b,
                                         input logic [CW-1:0] a);
    logic [CW:0] i;
    if (p < b) begin
      i = {1'b0, p};
    end else begin
      i = {1'b0, p} + (CW+1)'(CAPACITY) - {1'b0, b} - {1'b0, a};
    end
    return i[AW-1:0];
  endfunction

  assign len      = below + after;
  assign low_full = {{PROD_W{1'b0}}, prod} * {{PROD_W{1'b0}}, RECIP_100};
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign cur_ext  = {{POS_W{1'b0}}, cursor};
  assign len_ext  = {{POS_W{1'b0}}, len};
  assign scan_q   = cmd.neg || cmd.zero ? scan_p - CW'(1) : scan_p;

  always_comb begin
    if (buffer_size == '0) begin
      size_u = SIZE_W'(1);
    end else if (WW'(buffer_size) > WW'(CAPACITY)) begin
      size_u = SIZE_W'(CAPACITY);
    end else begin
      size_u = buffer_size;
    end
    warn_u = (warn_percent > WARN_MAX) ? WARN_MAX : warn_percent;
    gap_w  = (WW'(size_u) > WW'(len)) ? WW'(size_u) - WW'(len) : '0;
    p_s    = {1'b0, WW'(cursor)} + (WW+1)'(cmd.cnt);
    p_ok   = !p_s[WW] && (p_s[WW-1:0] < WW'(len));
    d_len  = WW'(len) - WW'(cursor);
    d_p    = WW'(scan_p) - WW'(cursor);
    d_p1   = WW'(scan_p) + WW'(1) - WW'(cursor);
    d_zero = '0 - WW'(cursor);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    case (state)
      S_GAP_RD: begin
        rd_en   = 1'b1;
        rd_addr = (below > cursor) ? AW'(below - CW'(1))
                                   : AW'(CW'(CAPACITY) - after);
      end
      S_GAP_WR: begin
        wr_en   = 1'b1;
        wr_addr = gap_back ? AW'(CW'(CAPACITY) - after - CW'(1)) : AW'(below);
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = AW'(below);
        wr_data = cmd.ch;
      end
      S_RD_ISSUE: begin
        rd_en   = 1'b1;
        rd_addr = phys(scan_p, below, after);
      end
      S_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = phys(scan_q, below, after);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      below    <= '0;
      after    <= '0;
      cursor   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd        <= cmd_in;
            res_status <= ST_OK;
            res_char   <= '0;
            res_cvalid <= 1'b0;
            res_dist   <= '0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          case (cmd.kind)
            K_INSERT: begin
              if (cmd.ch == CHAR_CR) begin
                state <= S_DONE;
              end else if (gap_w == '0) begin
                res_status <= ST_ERR;
              end else begin
                post_ins <= 1'b1;
                state    <= S_MUL1;
              end
            end
            K_DELETE: begin
              post_ins <= 1'b0;
              if (cmd.zero) begin
                state <= S_DONE;
              end else if (cmd.neg ? (WW'(cmd.mag) > WW'(cursor))
                                   : (WW'(cmd.mag) > d_len)) begin
                res_status <= ST_ERR;
              end else begin
                state <= S_GAP_RD;
              end
            end
            K_MOVE: begin
              if (cmd.zero) begin
                state <= S_DONE;
              end else if (!cmd.neg) begin
                if (WW'(cmd.mag) > d_len) begin
                  res_status <= ST_ERR;
                  if (cmd.clamp) begin
                    cursor <= len;
                  end
                end else begin
                  cursor <= cursor + CW'(cmd.mag);
                end
              end else begin
                if (WW'(cmd.mag) > WW'(cursor)) begin
                  res_status <= ST_ERR;
                  if (cmd.clamp) begin
                    cursor <= '0;
                  end
                end else begin
                  cursor <= cursor - CW'(cmd.mag);
                end
              end
            end
            K_JUMP: begin
              if (cmd.neg || (WW'(cmd.mag) > WW'(len))) begin
                res_status <= ST_ERR;
              end else begin
                cursor <= CW'(cmd.mag);
              end
            end
            K_READ: begin
              if (p_ok) begin
                scan_p <= p_s[CW-1:0];
                state  <= S_RD_ISSUE;
              end else begin
                res_status <= ST_ERR;
              end
            end
            K_CLEAR: begin
              below  <= '0;
              after  <= '0;
              cursor <= '0;
            end
            K_LINE: begin
              scan_p <= cursor;
              found  <= '0;
              state  <= S_SCAN_RD;
            end
            default: begin
              res_status <= ST_ERR;
            end
          endcase
        end
        S_MUL1: begin
          prod  <= PROD_W'(size_u) * PROD_W'(warn_u);
          state <= S_MUL2;
        end
        S_MUL2: begin
          low   <= SIZE_W'(size_u - low_full[RECIP_SHIFT+SIZE_W-1:RECIP_SHIFT]);
          state <= S_GAP_RD;
        end
        S_GAP_RD: begin
          if (below > cursor) begin
            gap_back <= 1'b1;
            state    <= S_GAP_WR;
          end else if (below < cursor && after != '0) begin
            gap_back <= 1'b0;
            state    <= S_GAP_WR;
          end else begin
            state <= post_ins ? S_INS : S_DEL;
          end
        end
        S_GAP_WR: begin
          if (gap_back) begin
            below <= below - CW'(1);
            after <= after + CW'(1);
          end else begin
            below <= below + CW'(1);
            after <= after - CW'(1);
          end
          state <= S_GAP_RD;
        end
        S_INS: begin
          below  <= below + CW'(1);
          cursor <= cursor + CW'(1);
          if (gap_w == WW'(1)) begin
            res_status <= ST_FULL;
          end else if (gap_w - WW'(1) <= WW'(low)) begin
            res_status <= ST_WARN;
          end
          state <= S_DONE;
        end
        S_DEL: begin
          if (cmd.neg) begin
            below  <= below - CW'(cmd.mag);
            cursor <= cursor - CW'(cmd.mag);
          end else begin
            after <= after - CW'(cmd.mag);
          end
          state <= S_DONE;
        end
        S_RD_ISSUE: begin
          state <= S_RD_TAKE;
        end
        S_RD_TAKE: begin
          res_char   <= rd_data;
          res_cvalid <= 1'b1;
          state      <= S_DONE;
        end
        S_SCAN_RD: begin
          if (!cmd.neg && !cmd.zero) begin
            if (scan_p >= len) begin
              res_dist <= d_len[COUNT_W-1:0];
              state    <= S_DONE;
            end else begin
              state <= S_SCAN_CHK;
            end
          end else begin
            if (scan_p == '0) begin
              res_dist <= d_zero[COUNT_W-1:0];
              state    <= S_DONE;
            end else begin
              state <= S_SCAN_CHK;
            end
          end
        end
        S_SCAN_CHK: begin
          state <= S_SCAN_RD;
          if (!cmd.neg && !cmd.zero) begin
            scan_p <= scan_p + CW'(1);
            if (is_term(rd_data)) begin
              found <= found + COUNT_W'(1);
              if (found + COUNT_W'(1) == cmd.mag) begin
                res_dist <= d_p1[COUNT_W-1:0];
                state    <= S_DONE;
              end
            end
          end else begin
            scan_p <= scan_p - CW'(1);
            if (is_term(rd_data)) begin
              found <= found + COUNT_W'(1);
              if (found == cmd.mag) begin
                res_dist <= d_p[COUNT_W-1:0];
                state    <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {len_ext[POS_W-1:0], cur_ext[POS_W-1:0], res_dist, res_char};
            m_tuser  <= {res_cvalid, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/gap_buffer_text_engine_core.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text engine
// Text store with a cursor: insert, delete, move, jump, read, clear and line search.
//
//   Channel   Dir  Handshake          Payload
//   s_axis    in   tvalid / tready    tuser opcode, tdata char_in count clamp
//   m_axis    out  tvalid / tready    tuser status char_valid, tdata result
//   cfg       in   cfg_valid / ready  cfg_index, cfg_data
//
// Insert and delete first move the gap to the cursor one byte at a time, with
// one store read and one store write per byte; a line search reads the store
// one byte at a time.
// Reset clears the cursor and text counts; the store itself is not cleared.
// A waiting result does not stop the next command from running.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_text_engine_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [23:0]  s_axis_tdata,   // char_in[7:0], count[21:8], clamp[22]
  input  wire logic [2:0]   s_axis_tuser,   // opcode[2:0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [47:0]       m_axis_tdata,   // char_out, distance, cursor, text_length
  output logic [2:0]        m_axis_tuser,   // status[1:0], char_valid[2]
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [12:0]  cfg_data
);
  import gbte_pkg::*;

  logic [SIZE_W-1:0] buffer_size;
  logic [WARN_W-1:0] warn_percent;
  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size  <= SIZE_W'(CAPACITY);
      warn_percent <= WARN_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BUFFER_SIZE:  buffer_size  <= cfg_data;
        CFG_WARN_PERCENT: warn_percent <= cfg_data[WARN_W-1:0];
        default:          buffer_size  <= buffer_size;
      endcase
    end
  end

  gbte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  gbte_back u_back (
    .clk          (clk),
    .rst          (rst),
    .buffer_size  (buffer_size),
    .warn_percent (warn_percent),
    .cmd_valid    (cmd_valid),
    .cmd_in       (cmd),
    .cmd_pop      (cmd_pop),
    .m_tvalid     (m_axis_tvalid),
    .m_tready     (m_axis_tready),
    .m_tdata      (m_axis_tdata),
    .m_tuser      (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== src/gbte_checker.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text engine checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbte_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result beat changed while stalled.");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Result beat shown right after reset.");

  a_cursor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[34:22] <= m_axis_tdata[47:35])
    else $error("Cursor lies beyond the text end.");

  a_char: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == 2'd0)
    else $error("Valid character with a failing status.");

  a_dist: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[21:8] != 14'd0 |-> !m_axis_tuser[2]
      && m_axis_tuser[1:0] == 2'd0)
    else $error("Line distance on a result that is not a line search.");

endmodule

bind gap_buffer_text_engine_core gbte_checker u_gbte_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== bench/gbte_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gap buffer text engine scoreboard
// Watches the command, result and register channels, keeps its own copy of
// the text, the cursor and the registers, and checks every result beat field
// by field against the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module gbte_scoreboard (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [23:0]  s_axis_tdata,
  input  wire logic [2:0]   s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [47:0]  m_axis_tdata,
  input  wire logic [2:0]   m_axis_tuser,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [12:0]  cfg_data,
  output int                pending,
  output int                errors,
  output int                results_seen
);
  import gbte_pkg::*;

  typedef struct {
    logic [1:0]                status;
    logic [CHAR_W-1:0]         char_out;
    logic                      char_valid;
    logic signed [COUNT_W-1:0] distance;
    logic [POS_W-1:0]          cursor;
    logic [POS_W-1:0]          text_length;
  } answer_t;

  answer_t            answers_q[$];
  logic [CHAR_W-1:0]  text_q[$];
  int                 cur;
  logic [SIZE_W-1:0]  size_reg;
  logic [WARN_W-1:0]  warn_reg;

  assign pending = answers_q.size();

  task automatic report(input string field, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  function automatic bit is_line_end(input logic [CHAR_W-1:0] c);
    return c == CHAR_LF || c == CHAR_VT || c == CHAR_FF;
  endfunction

  task automatic apply_command(input logic [2:0] op, input logic [CHAR_W-1:0] ch,
                               input logic signed [COUNT_W-1:0] cnt_in, input logic clamp);
    answer_t a;
    int cnt, mag, len, size, warn, low, gap, p, found, target;
    cnt = cnt_in;
    mag = cnt < 0 ? -cnt : cnt;
    len = text_q.size();
    a.status = ST_OK;
    a.char_out = '0;
    a.char_valid = 1'b0;
    a.distance = '0;
    case (op)
      OP_INSERT: begin
        size = size_reg < 1 ? 1 : (size_reg > CAPACITY ? CAPACITY : size_reg);
        warn = warn_reg > WARN_MAX ? WARN_MAX : warn_reg;
        low = size - (size * warn) / 100;
        gap = size > len ? size - len : 0;
        if (ch != CHAR_CR) begin
          if (gap == 0) begin
            a.status = ST_ERR;
          end else begin
            text_q.insert(cur, ch);
            cur++;
            gap--;
            if (gap == 0) a.status = ST_FULL;
            else if (gap <= low) a.status = ST_WARN;
          end
        end
      end
      OP_DELETE: begin
        if (cnt < 0) begin
          if (mag > cur) begin
            a.status = ST_ERR;
          end else begin
            repeat (mag) text_q.delete(cur - mag);
            cur -= mag;
          end
        end else if (cnt > 0) begin
          if (mag > len - cur) a.status = ST_ERR;
          else repeat (mag) text_q.delete(cur);
        end
      end
      OP_MOVE: begin
        if (cnt > 0) begin
          if (mag > len - cur) begin
            a.status = ST_ERR;
            if (clamp) cur = len;
          end else begin
            cur += mag;
          end
        end else if (cnt < 0) begin
          if (mag > cur) begin
            a.status = ST_ERR;
            if (clamp) cur = 0;
          end else begin
            cur -= mag;
          end
        end
      end
      OP_JUMP: begin
        if (cnt < 0 || mag > len) a.status = ST_ERR;
        else cur = mag;
      end
      OP_READ: begin
        p = cur + cnt;
        if (p >= 0 && p < len) begin
          a.char_out = text_q[p];
          a.char_valid = 1'b1;
        end else begin
          a.status = ST_ERR;
        end
      end
      OP_CLEAR: begin
        text_q.delete();
        cur = 0;
      end
      OP_LINE: begin
        found = 0;
        if (cnt > 0) begin
          target = len;
          for (p = cur; p < len; p++) begin
            if (is_line_end(text_q[p])) begin
              found++;
              if (found == mag) begin
                target = p + 1;
                break;
              end
            end
          end
        end else begin
          target = 0;
          for (p = cur; p > 0; p--) begin
            if (is_line_end(text_q[p-1])) begin
              if (found == mag) begin
                target = p;
                break;
              end
              found++;
            end
          end
        end
        a.distance = COUNT_W'(target - cur);
      end
      default: a.status = ST_ERR;
    endcase
    a.cursor = POS_W'(cur);
    a.text_length = POS_W'(text_q.size());
    answers_q.push_back(a);
  endtask

  always @(posedge clk) begin
    answer_t w;
    if (rst) begin
      answers_q.delete();
      text_q.delete();
      cur = 0;
      size_reg = SIZE_W'(CAPACITY);
      warn_reg = WARN_MAX;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BUFFER_SIZE) size_reg = cfg_data;
        else warn_reg = cfg_data[WARN_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_command(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[21:8], s_axis_tdata[22]);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (answers_q.size() == 0) begin
          report("unexpected result beat", 1, 0);
        end else begin
          w = answers_q.pop_front();
          if (m_axis_tuser[1:0] != w.status) report("status", m_axis_tuser[1:0], w.status);
          if (m_axis_tuser[2] != w.char_valid)
            report("char_valid", m_axis_tuser[2], w.char_valid);
          if (m_axis_tdata[7:0] != w.char_out) report("char_out", m_axis_tdata[7:0], w.char_out);
          if (m_axis_tdata[21:8] != w.distance)
            report("distance", $signed(m_axis_tdata[21:8]), w.distance);
          if (m_axis_tdata[34:22] != w.cursor) report("cursor", m_axis_tdata[34:22], w.cursor);
          if (m_axis_tdata[47:35] != w.text_length)
            report("text_length", m_axis_tdata[47:35], w.text_length);
        end
      end
    end
  end

  initial begin
    errors = 0;
    results_seen = 0;
  end

endmodule

`default_nettype wire

// ===== bench/tb_gap_buffer_text_engine_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gap buffer text engine testbench
// Drives directed and random edit commands through several register settings
// with random idling on both sides and one long result hold-off; the
// scoreboard checks every result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gap_buffer_text_engine_core;
  import gbte_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [12:0] cfg_data;
  int          pending;
  int          errors;
  int          results_seen;
  int          cycles;
  int          commands_sent;
  logic        quiet;
  logic        hold_req;

  gap_buffer_text_engine_core u_top (.*);

  gbte_scoreboard u_scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || $urandom_range(0, 99) >= 31;
      end
    end
  end

  task automatic send_cmd(input logic [2:0] op, input logic [7:0] ch,
                          input int cnt, input bit clamp);
    logic [COUNT_W-1:0] c;
    c = COUNT_W'(cnt);
    while (!quiet && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {1'b0, clamp, c, ch};
    do @(posedge clk); while (!s_axis_tready);
    commands_sent++;
  endtask

  task automatic write_reg(input logic idx, input int value);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= SIZE_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_cmd();
    int pick, cnt;
    logic [2:0] op;
    logic [7:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 36) op = OP_INSERT;
    else if (pick < 48) op = OP_DELETE;
    else if (pick < 60) op = OP_MOVE;
    else if (pick < 68) op = OP_JUMP;
    else if (pick < 81) op = OP_READ;
    else if (pick < 83) op = OP_CLEAR;
    else if (pick < 99) op = OP_LINE;
    else op = OP_UNUSED;
    if ($urandom_range(0, 3) == 0) ch = CHAR_LF + 8'($urandom_range(0, 3));
    else ch = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) cnt = $urandom_range(0, 8192) - 4096;
    else if (op == OP_JUMP) cnt = $urandom_range(0, 40) - 2;
    else cnt = $urandom_range(0, 16) - 8;
    send_cmd(op, ch, cnt, $urandom_range(0, 1));
  endtask

  initial begin
    int sizes[6];
    int warns[6];
    rst = 1'b1;
    cycles = 0;
    commands_sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    sizes = '{16, 1, 0, 8191, 200, 4096};
    warns = '{50, 0, 127, 100, 75, 37};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(OP_READ, 8'h00, 0, 0);
    send_cmd(OP_LINE, 8'h00, 1, 0);
    send_cmd(OP_INSERT, 8'h00, 0, 0);
    send_cmd(OP_INSERT, 8'hFF, -4096, 1);
    send_cmd(OP_INSERT, CHAR_CR, 0, 0);
    send_cmd(OP_INSERT, CHAR_LF, 0, 0);
    send_cmd(OP_INSERT, CHAR_VT, 0, 0);
    send_cmd(OP_INSERT, 8'h41, 0, 0);
    send_cmd(OP_INSERT, CHAR_FF, 0, 0);
    send_cmd(OP_LINE, 8'h00, 0, 0);
    send_cmd(OP_LINE, 8'h00, -1, 0);
    send_cmd(OP_LINE, 8'h00, -4096, 0);
    send_cmd(OP_JUMP, 8'h00, 0, 0);
    send_cmd(OP_LINE, 8'h00, 2, 0);
    send_cmd(OP_LINE, 8'h00, 4096, 0);
    send_cmd(OP_READ, 8'h00, -1, 0);
    send_cmd(OP_READ, 8'h00, 4096, 0);
    send_cmd(OP_READ, 8'h00, 3, 0);
    send_cmd(OP_JUMP, 8'h00, -1, 0);
    send_cmd(OP_JUMP, 8'h00, 4096, 0);
    send_cmd(OP_MOVE, 8'h00, 4096, 1);
    send_cmd(OP_MOVE, 8'h00, -4096, 0);
    send_cmd(OP_MOVE, 8'h00, -4096, 1);
    send_cmd(OP_DELETE, 8'h00, -1, 0);
    send_cmd(OP_DELETE, 8'h00, 4096, 0);
    send_cmd(OP_DELETE, 8'h00, 1, 0);
    send_cmd(OP_CLEAR, 8'h00, 0, 0);
    send_cmd(OP_UNUSED, 8'h00, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_BUFFER_SIZE, sizes[ph]);
      write_reg(CFG_WARN_PERCENT, warns[ph]);
      quiet = (ph == 4);
      for (int i = 0; i < 237; i++) begin
        if (ph == 2 && i == 40) hold_req <= 1'b1;
        random_cmd();
      end
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d commands and checked %0d results over six register settings,",
             commands_sent, results_seen);
    $display("including a full store, a shrunken size and a long result hold-off.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
